### rtl/core/rvdx_pkg.sv
// Shared types, opcodes and widths for the RV32I decode and execute stage.
package rvdx_pkg;

   localparam int XLEN      = 32;
   localparam int REG_IDX_W = 5;
   localparam int OPC_W     = 7;
   localparam int F3_W      = 3;
   localparam int FWD_W     = 2;
   localparam int SHAMT_W   = 5;

   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = 1;
   localparam int QCNT_W    = 2;

   localparam logic [OPC_W-1:0] OPC_LOAD   = 7'h03;
   localparam logic [OPC_W-1:0] OPC_OPIMM  = 7'h13;
   localparam logic [OPC_W-1:0] OPC_AUIPC  = 7'h17;
   localparam logic [OPC_W-1:0] OPC_STORE  = 7'h23;
   localparam logic [OPC_W-1:0] OPC_OP     = 7'h33;
   localparam logic [OPC_W-1:0] OPC_LUI    = 7'h37;
   localparam logic [OPC_W-1:0] OPC_BRANCH = 7'h63;

   localparam logic [FWD_W-1:0] FWD_WB  = 2'd1;
   localparam logic [FWD_W-1:0] FWD_MEM = 2'd2;

   localparam logic [F3_W-1:0] F3_ADD  = 3'd0;
   localparam logic [F3_W-1:0] F3_SLL  = 3'd1;
   localparam logic [F3_W-1:0] F3_SLT  = 3'd2;
   localparam logic [F3_W-1:0] F3_SLTU = 3'd3;
   localparam logic [F3_W-1:0] F3_XOR  = 3'd4;
   localparam logic [F3_W-1:0] F3_SR   = 3'd5;
   localparam logic [F3_W-1:0] F3_OR   = 3'd6;
   localparam logic [F3_W-1:0] F3_AND  = 3'd7;

   typedef struct packed {
      logic [OPC_W-1:0]     opcode;
      logic [F3_W-1:0]      funct3;
      logic                 alt;
      logic [XLEN-1:0]      pc;
      logic [XLEN-1:0]      imm;
      logic [XLEN-1:0]      opa;
      logic [XLEN-1:0]      opb;
      logic [REG_IDX_W-1:0] rd;
      logic [REG_IDX_W-1:0] rs1;
      logic [REG_IDX_W-1:0] rs2;
      logic                 dest_write;
      logic                 load_flag;
      logic                 store_flag;
      logic                 branch_flag;
   } dec_type;

   typedef struct packed {
      logic    push;
      dec_type entry;
   } queue_wr_type;

   typedef struct packed {
      logic    avail;
      dec_type entry;
   } queue_rd_type;

endpackage

### rtl/core/rvdx_req_if.sv
// Instruction channel: valid, ready and the instruction beat payload.
interface rvdx_req_if;
   logic                         valid;
   logic                         ready;
   logic [rvdx_pkg::XLEN-1:0]    instruction;
   logic [rvdx_pkg::XLEN-1:0]    inst_pc;
   logic [rvdx_pkg::XLEN-1:0]    src1_regval;
   logic [rvdx_pkg::XLEN-1:0]    src2_regval;
   logic [rvdx_pkg::FWD_W-1:0]   fwd_sel_a;
   logic [rvdx_pkg::FWD_W-1:0]   fwd_sel_b;
   logic [rvdx_pkg::XLEN-1:0]    writeback_value;
   logic [rvdx_pkg::XLEN-1:0]    memstage_value;
   logic                         flush;

   modport source (output valid, instruction, inst_pc, src1_regval, src2_regval,
                   fwd_sel_a, fwd_sel_b, writeback_value, memstage_value, flush,
                   input ready);
   modport sink (input valid, instruction, inst_pc, src1_regval, src2_regval,
                 fwd_sel_a, fwd_sel_b, writeback_value, memstage_value, flush,
                 output ready);
endinterface

### rtl/core/rvdx_rsp_if.sv
// Result channel: valid, ready and the execute result beat payload.
interface rvdx_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rvdx_pkg::XLEN-1:0]       exec_value;
   logic [rvdx_pkg::XLEN-1:0]       store_data;
   logic [rvdx_pkg::REG_IDX_W-1:0]  dest_reg;
   logic [rvdx_pkg::REG_IDX_W-1:0]  src1_index;
   logic [rvdx_pkg::REG_IDX_W-1:0]  src2_index;
   logic [rvdx_pkg::XLEN-1:0]       immediate;
   logic                            dest_write;
   logic                            load_flag;
   logic                            store_flag;
   logic                            branch_flag;

   modport source (output valid, exec_value, store_data, dest_reg, src1_index,
                   src2_index, immediate, dest_write, load_flag, store_flag,
                   branch_flag, input ready);
   modport sink (input valid, exec_value, store_data, dest_reg, src1_index,
                 src2_index, immediate, dest_write, load_flag, store_flag,
                 branch_flag, output ready);
endinterface

### rtl/core/rvdx_front.sv
// Front end: accepts instruction beats, decodes fields, immediates and forwarding.
module rvdx_front (
   rvdx_req_if.sink               req_chan,
   input  logic                   req_queue_full,
   output rvdx_pkg::queue_wr_type req_queue_wr
);
   import rvdx_pkg::*;

   logic [XLEN-1:0] inst;
   logic [XLEN-1:0] imm;
   logic [XLEN-1:0] reg_a;
   logic [XLEN-1:0] reg_b;
   logic            rw;
   logic            mr;
   logic            mw;
   logic            br;
   dec_type         dec;

   assign inst = req_chan.instruction;
   assign req_chan.ready = !req_queue_full;

   always_comb begin
      imm = '0;
      rw  = 1'b0;
      mr  = 1'b0;
      mw  = 1'b0;
      br  = 1'b0;
      case (inst[OPC_W-1:0])
         OPC_OPIMM: begin
            imm = {{20{inst[31]}}, inst[31:20]};
            rw  = 1'b1;
         end
         OPC_OP: begin
            rw = 1'b1;
         end
         OPC_LUI, OPC_AUIPC: begin
            imm = {inst[31:12], 12'b0};
            rw  = 1'b1;
         end
         OPC_STORE: begin
            imm = {{20{inst[31]}}, inst[31:25], inst[11:7]};
            mw  = 1'b1;
         end
         OPC_LOAD: begin
            imm = {{20{inst[31]}}, inst[31:20]};
            rw  = 1'b1;
            mr  = 1'b1;
         end
         OPC_BRANCH: begin
            imm = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
            br  = 1'b1;
         end
         default: begin
            imm = '0;
         end
      endcase
   end

   always_comb begin
      reg_a = (inst[19:15] != '0) ? req_chan.src1_regval : '0;
      reg_b = (inst[24:20] != '0) ? req_chan.src2_regval : '0;
      dec.opa = (req_chan.fwd_sel_a == FWD_WB)  ? req_chan.writeback_value :
                (req_chan.fwd_sel_a == FWD_MEM) ? req_chan.memstage_value  : reg_a;
      dec.opb = (req_chan.fwd_sel_b == FWD_WB)  ? req_chan.writeback_value :
                (req_chan.fwd_sel_b == FWD_MEM) ? req_chan.memstage_value  : reg_b;
      dec.opcode      = inst[OPC_W-1:0];
      dec.funct3      = inst[14:12];
      dec.alt         = inst[30];
      dec.pc          = req_chan.inst_pc;
      dec.imm         = imm;
      dec.rd          = inst[11:7];
      dec.rs1         = inst[19:15];
      dec.rs2         = inst[24:20];
      dec.dest_write  = rw;
      dec.load_flag   = mr;
      dec.store_flag  = mw;
      dec.branch_flag = br;
   end

   // A flushed beat enters the queue as an all-zero bubble.
   assign req_queue_wr.push  = req_chan.valid && !req_queue_full;
   assign req_queue_wr.entry = req_chan.flush ? '0 : dec;

endmodule

### rtl/core/rvdx_queue.sv
// Two-entry queue of decoded instructions between the front and back ends.
module rvdx_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  rvdx_pkg::queue_wr_type queue_wr,
   input  logic                   queue_pop,
   output logic                   queue_full,
   output rvdx_pkg::queue_rd_type queue_rd
);
   import rvdx_pkg::*;

   dec_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_pop;

   assign queue_full     = (count_ff == QCNT_W'(QDEPTH));
   assign queue_rd.avail = (count_ff != '0);
   assign queue_rd.entry = slot_ff[rd_ptr_ff];
   assign do_pop         = queue_pop && queue_rd.avail;

   always_comb begin
      wr_ptr_in = queue_wr.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(queue_wr.push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_wr.push) begin
         slot_ff[wr_ptr_ff] <= queue_wr.entry;
      end
   end

endmodule

### rtl/core/rvdx_back.sv
// Back end: runs the RV32I ALU on a queued instruction and holds the result beat.
module rvdx_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rvdx_pkg::queue_rd_type queue_rd,
   output logic                   queue_pop,
   rvdx_rsp_if.source             rsp_chan
);
   import rvdx_pkg::*;

   dec_type              e;
   logic [XLEN-1:0]      op_b;
   logic [SHAMT_W-1:0]   sh;
   logic [XLEN-1:0]      alu_out;
   logic [XLEN-1:0]      res;

   logic                 valid_ff;
   logic                 valid_in;
   logic [XLEN-1:0]      result_ff;
   logic [XLEN-1:0]      store_ff;
   logic [REG_IDX_W-1:0] rd_ff;
   logic [REG_IDX_W-1:0] rs1_ff;
   logic [REG_IDX_W-1:0] rs2_ff;
   logic [XLEN-1:0]      imm_ff;
   logic                 rw_ff;
   logic                 mr_ff;
   logic                 mw_ff;
   logic                 br_ff;

   assign e         = queue_rd.entry;
   assign queue_pop = queue_rd.avail && (!valid_ff || rsp_chan.ready);

   always_comb begin
      op_b = (e.opcode == OPC_OPIMM) ? e.imm : e.opb;
      sh   = op_b[SHAMT_W-1:0];
      case (e.funct3)
         F3_ADD:  alu_out = (e.opcode == OPC_OP && e.alt) ? e.opa - op_b : e.opa + op_b;
         F3_SLL:  alu_out = e.opa << sh;
         F3_SLT:  alu_out = XLEN'($signed(e.opa) < $signed(op_b));
         F3_SLTU: alu_out = XLEN'(e.opa < op_b);
         F3_XOR:  alu_out = e.opa ^ op_b;
         F3_SR:   alu_out = e.alt ? XLEN'($signed(e.opa) >>> sh) : e.opa >> sh;
         F3_OR:   alu_out = e.opa | op_b;
         F3_AND:  alu_out = e.opa & op_b;
         default: alu_out = e.opa & op_b;
      endcase
      case (e.opcode)
         OPC_LUI:   res = e.imm;
         OPC_AUIPC: res = e.pc + e.imm;
         OPC_LOAD:  res = e.opa + e.imm;
         OPC_STORE: res = e.opa + e.imm;
         default:   res = alu_out;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (queue_pop) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         result_ff <= res;
         store_ff  <= e.opb;
         rd_ff     <= e.rd;
         rs1_ff    <= e.rs1;
         rs2_ff    <= e.rs2;
         imm_ff    <= e.imm;
         rw_ff     <= e.dest_write;
         mr_ff     <= e.load_flag;
         mw_ff     <= e.store_flag;
         br_ff     <= e.branch_flag;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.exec_value  = result_ff;
   assign rsp_chan.store_data  = store_ff;
   assign rsp_chan.dest_reg    = rd_ff;
   assign rsp_chan.src1_index  = rs1_ff;
   assign rsp_chan.src2_index  = rs2_ff;
   assign rsp_chan.immediate   = imm_ff;
   assign rsp_chan.dest_write  = rw_ff;
   assign rsp_chan.load_flag   = mr_ff;
   assign rsp_chan.store_flag  = mw_ff;
   assign rsp_chan.branch_flag = br_ff;

endmodule

### rtl/core/rv32i_decode_execute_stage_top.sv
// Top level of the RV32I decode and execute stage: front end, queue, back end.
//
//   Channel    Port      Direction  Beat
//   request    req_chan  in         instruction, pc, operands, forwarding, flush
//   response   rsp_chan  out        ALU result, store data, indices, immediate, flags
//
// One beat is accepted per cycle while the two-entry queue has room.
// A request beat is written into the queue; the back end then pops it into the result register.
// The queue and the result register let either side stall on its own.
// Reset is synchronous and empties the queue and the result register.
module rv32i_decode_execute_stage_top (
   input logic        clock,
   input logic        reset,
   rvdx_req_if.sink   req_chan,
   rvdx_rsp_if.source rsp_chan
);
   import rvdx_pkg::*;

   queue_wr_type queue_wr;
   queue_rd_type queue_rd;
   logic         queue_full;
   logic         queue_pop;

   rvdx_front u_front (
      .req_chan       (req_chan),
      .req_queue_full (queue_full),
      .req_queue_wr   (queue_wr)
   );

   rvdx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_wr   (queue_wr),
      .queue_pop  (queue_pop),
      .queue_full (queue_full),
      .queue_rd   (queue_rd)
   );

   rvdx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .queue_rd  (queue_rd),
      .queue_pop (queue_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

### rtl/core/rvdx_checker.sv
// Port-level assertions for the decode and execute stage, bound to the top level.
module rvdx_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [31:0]           rsp_exec_value,
   input logic                  rsp_dest_write,
   input logic                  rsp_load_flag,
   input logic                  rsp_store_flag,
   input logic                  rsp_branch_flag
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result beat valid right after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_exec_value))
      else $error("Stalled result beat changed.");

   a_load_writes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_load_flag |-> rsp_dest_write && !rsp_store_flag)
      else $error("Load beat without register write or with store flag.");

   a_no_write_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_store_flag || rsp_branch_flag) |-> !rsp_dest_write)
      else $error("Store or branch beat marked as register write.");

endmodule

bind rv32i_decode_execute_stage_top rvdx_checker u_rvdx_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_exec_value  (rsp_chan.exec_value),
   .rsp_dest_write  (rsp_chan.dest_write),
   .rsp_load_flag   (rsp_chan.load_flag),
   .rsp_store_flag  (rsp_chan.store_flag),
   .rsp_branch_flag (rsp_chan.branch_flag)
);

### tb/rv32i_decode_execute_stage_top_tb.sv
// Self-checking testbench for the RV32I decode and execute stage top level.
module rv32i_decode_execute_stage_top_tb;
   import rvdx_pkg::*;

   localparam logic [OPC_W-1:0] OPC_JAL   = 7'h6F;
   localparam logic [OPC_W-1:0] OPC_JALR  = 7'h67;
   localparam logic [FWD_W-1:0] FWD_REG   = 2'd0;
   localparam logic [FWD_W-1:0] FWD_SPARE = 2'd3;
   localparam int RANDOM_BEATS = 1350;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [XLEN-1:0]  instruction;
      logic [XLEN-1:0]  inst_pc;
      logic [XLEN-1:0]  src1_regval;
      logic [XLEN-1:0]  src2_regval;
      logic [FWD_W-1:0] fwd_sel_a;
      logic [FWD_W-1:0] fwd_sel_b;
      logic [XLEN-1:0]  writeback_value;
      logic [XLEN-1:0]  memstage_value;
      logic             flush;
   } instr_beat_type;

   typedef struct packed {
      logic [XLEN-1:0]      exec_value;
      logic [XLEN-1:0]      store_data;
      logic [REG_IDX_W-1:0] dest_reg;
      logic [REG_IDX_W-1:0] src1_index;
      logic [REG_IDX_W-1:0] src2_index;
      logic [XLEN-1:0]      immediate;
      logic                 dest_write;
      logic                 load_flag;
      logic                 store_flag;
      logic                 branch_flag;
   } exec_result_type;

   class exec_scoreboard_type;
      exec_result_type pending_results[$];
      int              mismatches;

      function logic [XLEN-1:0] select_operand(logic [FWD_W-1:0] sel, logic [XLEN-1:0] regval,
                                               logic [XLEN-1:0] wb, logic [XLEN-1:0] mem);
         case (sel)
            FWD_WB:  return wb;
            FWD_MEM: return mem;
            default: return regval;
         endcase
      endfunction

      function exec_result_type execute(instr_beat_type b);
         logic [OPC_W-1:0]   opc;
         logic [F3_W-1:0]    f3;
         logic               alt;
         logic [XLEN-1:0]    imm;
         logic [XLEN-1:0]    opa;
         logic [XLEN-1:0]    opb;
         logic [XLEN-1:0]    rhs;
         logic [XLEN-1:0]    res;
         logic [SHAMT_W-1:0] sh;
         exec_result_type    r;
         r = '0;
         if (b.flush)
            return r;
         opc = b.instruction[6:0];
         f3 = b.instruction[14:12];
         alt = b.instruction[30];
         r.dest_reg = b.instruction[11:7];
         r.src1_index = b.instruction[19:15];
         r.src2_index = b.instruction[24:20];
         imm = '0;
         case (opc)
            OPC_OPIMM: begin
               imm = {{20{b.instruction[31]}}, b.instruction[31:20]};
               r.dest_write = 1'b1;
            end
            OPC_OP: r.dest_write = 1'b1;
            OPC_LUI, OPC_AUIPC: begin
               imm = {b.instruction[31:12], 12'h000};
               r.dest_write = 1'b1;
            end
            OPC_STORE: begin
               imm = {{20{b.instruction[31]}}, b.instruction[31:25], b.instruction[11:7]};
               r.store_flag = 1'b1;
            end
            OPC_LOAD: begin
               imm = {{20{b.instruction[31]}}, b.instruction[31:20]};
               r.dest_write = 1'b1;
               r.load_flag = 1'b1;
            end
            OPC_BRANCH: begin
               imm = {{19{b.instruction[31]}}, b.instruction[31], b.instruction[7],
                      b.instruction[30:25], b.instruction[11:8], 1'b0};
               r.branch_flag = 1'b1;
            end
            default: ;
         endcase
         opa = select_operand(b.fwd_sel_a, (r.src1_index != 0) ? b.src1_regval : 32'h0,
                              b.writeback_value, b.memstage_value);
         opb = select_operand(b.fwd_sel_b, (r.src2_index != 0) ? b.src2_regval : 32'h0,
                              b.writeback_value, b.memstage_value);
         rhs = (opc == OPC_OPIMM) ? imm : opb;
         sh = rhs[SHAMT_W-1:0];
         if (opc == OPC_LUI)
            res = imm;
         else if (opc == OPC_AUIPC)
            res = b.inst_pc + imm;
         else if (opc == OPC_LOAD || opc == OPC_STORE)
            res = opa + imm;
         else begin
            case (f3)
               F3_ADD: begin
                  if (opc == OPC_OP && alt)
                     res = opa - rhs;
                  else
                     res = opa + rhs;
               end
               F3_SLL:  res = opa << sh;
               F3_SLT:  res = ($signed(opa) < $signed(rhs)) ? 32'd1 : 32'd0;
               F3_SLTU: res = (opa < rhs) ? 32'd1 : 32'd0;
               F3_XOR:  res = opa ^ rhs;
               F3_SR: begin
                  if (alt)
                     res = $signed(opa) >>> sh;
                  else
                     res = opa >> sh;
               end
               F3_OR:   res = opa | rhs;
               default: res = opa & rhs;
            endcase
         end
         r.exec_value = res;
         r.store_data = opb;
         r.immediate = imm;
         return r;
      endfunction

      function void note_instruction(instr_beat_type b);
         pending_results.push_back(execute(b));
      endfunction

      function void compare(string field, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(exec_result_type got);
         exec_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got %h", $time, got);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         compare("exec_value", want.exec_value, got.exec_value);
         compare("store_data", want.store_data, got.store_data);
         compare("dest_reg", XLEN'(want.dest_reg), XLEN'(got.dest_reg));
         compare("src1_index", XLEN'(want.src1_index), XLEN'(got.src1_index));
         compare("src2_index", XLEN'(want.src2_index), XLEN'(got.src2_index));
         compare("immediate", want.immediate, got.immediate);
         compare("dest_write", XLEN'(want.dest_write), XLEN'(got.dest_write));
         compare("load_flag", XLEN'(want.load_flag), XLEN'(got.load_flag));
         compare("store_flag", XLEN'(want.store_flag), XLEN'(got.store_flag));
         compare("branch_flag", XLEN'(want.branch_flag), XLEN'(got.branch_flag));
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   throttle = 1'b1;
   bit   hold_off_armed = 1'b0;
   int   cycle_count = 0;
   exec_scoreboard_type board = new();

   rvdx_req_if req_bus();
   rvdx_rsp_if rsp_bus();

   rv32i_decode_execute_stage_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [XLEN-1:0] pick_operand_value();
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   function automatic instr_beat_type build_beat(logic [XLEN-1:0] instr, logic [XLEN-1:0] rv1,
                                                  logic [XLEN-1:0] rv2, logic [FWD_W-1:0] sa,
                                                  logic [FWD_W-1:0] sb);
      instr_beat_type b;
      b.instruction = instr;
      b.inst_pc = $urandom;
      b.src1_regval = rv1;
      b.src2_regval = rv2;
      b.fwd_sel_a = sa;
      b.fwd_sel_b = sb;
      b.writeback_value = $urandom;
      b.memstage_value = $urandom;
      b.flush = 1'b0;
      return b;
   endfunction

   function automatic instr_beat_type random_beat();
      logic [XLEN-1:0] instr;
      instr_beat_type  b;
      instr = $urandom;
      if ($urandom_range(99) < 88) begin
         case ($urandom_range(8))
            0: instr[6:0] = OPC_LOAD;
            1: instr[6:0] = OPC_OPIMM;
            2: instr[6:0] = OPC_AUIPC;
            3: instr[6:0] = OPC_STORE;
            4: instr[6:0] = OPC_OP;
            5: instr[6:0] = OPC_LUI;
            6: instr[6:0] = OPC_BRANCH;
            7: instr[6:0] = OPC_JAL;
            default: instr[6:0] = OPC_JALR;
         endcase
      end
      if ((instr[6:0] == OPC_OP || instr[6:0] == OPC_OPIMM) && $urandom_range(1))
         instr[31:25] = $urandom_range(1) ? 7'h20 : 7'h00;
      if ($urandom_range(7) == 0)
         instr[19:15] = '0;
      if ($urandom_range(7) == 0)
         instr[24:20] = '0;
      b = build_beat(instr, pick_operand_value(), pick_operand_value(),
                     FWD_W'($urandom_range(3)), FWD_W'($urandom_range(3)));
      b.inst_pc = pick_operand_value();
      b.writeback_value = pick_operand_value();
      b.memstage_value = pick_operand_value();
      b.flush = ($urandom_range(19) == 0);
      return b;
   endfunction

   task automatic issue_instruction(input instr_beat_type b);
      if (throttle && $urandom_range(99) < 20) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.instruction <= b.instruction;
      req_bus.inst_pc <= b.inst_pc;
      req_bus.src1_regval <= b.src1_regval;
      req_bus.src2_regval <= b.src2_regval;
      req_bus.fwd_sel_a <= b.fwd_sel_a;
      req_bus.fwd_sel_b <= b.fwd_sel_b;
      req_bus.writeback_value <= b.writeback_value;
      req_bus.memstage_value <= b.memstage_value;
      req_bus.flush <= b.flush;
      do @(posedge clock); while (!req_bus.ready);
      board.note_instruction(b);
   endtask

   initial begin
      int              hold_left;
      bit              hold_done;
      exec_result_type got;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{exec_value: rsp_bus.exec_value, store_data: rsp_bus.store_data,
                    dest_reg: rsp_bus.dest_reg, src1_index: rsp_bus.src1_index,
                    src2_index: rsp_bus.src2_index, immediate: rsp_bus.immediate,
                    dest_write: rsp_bus.dest_write, load_flag: rsp_bus.load_flag,
                    store_flag: rsp_bus.store_flag, branch_flag: rsp_bus.branch_flag};
            board.check_result(got);
         end
         if (hold_off_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else
            rsp_bus.ready <= !(throttle && $urandom_range(99) < 25);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[rv32i_decode_execute_stage_top] ERROR");
      $finish;
   end

   initial begin
      instr_beat_type b;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.instruction = '0;
      req_bus.inst_pc = '0;
      req_bus.src1_regval = '0;
      req_bus.src2_regval = '0;
      req_bus.fwd_sel_a = FWD_REG;
      req_bus.fwd_sel_b = FWD_REG;
      req_bus.writeback_value = '0;
      req_bus.memstage_value = '0;
      req_bus.flush = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Register-register arithmetic, with wraparound and signed compares.
      issue_instruction(build_beat({7'h00, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_OP},
                                   32'hFFFF_FFFF, 32'h1, FWD_REG, FWD_REG));
      issue_instruction(build_beat({7'h20, 5'd2, 5'd1, F3_ADD, 5'd31, OPC_OP},
                                   32'h0, 32'h1, FWD_REG, FWD_REG));
      issue_instruction(build_beat({7'h20, 5'd2, 5'd1, F3_SR, 5'd4, OPC_OP},
                                   32'h8000_0000, 32'h3F, FWD_REG, FWD_REG));
      issue_instruction(build_beat({7'h00, 5'd2, 5'd1, F3_SLT, 5'd5, OPC_OP},
                                   32'h8000_0000, 32'h7FFF_FFFF, FWD_REG, FWD_REG));
      // Every immediate operation, with the immediate at its extremes.
      issue_instruction(build_beat({12'hFFF, 5'd1, F3_ADD, 5'd6, OPC_OPIMM},
                                   32'h0, 32'h0, FWD_REG, FWD_REG));
      issue_instruction(build_beat({12'h01F, 5'd1, F3_SLL, 5'd6, OPC_OPIMM},
                                   32'hFFFF_FFFF, 32'h0, FWD_REG, FWD_REG));
      issue_instruction(build_beat({12'h800, 5'd1, F3_SLT, 5'd6, OPC_OPIMM},
                                   32'h8000_0000, 32'h0, FWD_REG, FWD_REG));
      issue_instruction(build_beat({12'hFFF, 5'd1, F3_SLTU, 5'd6, OPC_OPIMM},
                                   32'hFFFF_FFFE, 32'h0, FWD_REG, FWD_REG));
      issue_instruction(build_beat({12'h7FF, 5'd1, F3_XOR, 5'd6, OPC_OPIMM},
                                   32'hFFFF_FFFF, 32'h0, FWD_REG, FWD_REG));
      issue_instruction(build_beat({12'h41F, 5'd1, F3_SR, 5'd6, OPC_OPIMM},
                                   32'h8000_0000, 32'h0, FWD_REG, FWD_REG));
      issue_instruction(build_beat({12'h01F, 5'd1, F3_SR, 5'd6, OPC_OPIMM},
                                   32'h8000_0000, 32'h0, FWD_REG, FWD_REG));
      issue_instruction(build_beat({12'h800, 5'd1, F3_OR, 5'd6, OPC_OPIMM},
                                   32'h0000_0001, 32'h0, FWD_REG, FWD_REG));
      issue_instruction(build_beat({12'hFFF, 5'd1, F3_AND, 5'd6, OPC_OPIMM},
                                   32'h1234_5678, 32'h0, FWD_REG, FWD_REG));
      // Upper immediates, loads, stores and branches.
      issue_instruction(build_beat({20'hFFFFF, 5'd7, OPC_LUI},
                                   32'h0, 32'h0, FWD_REG, FWD_REG));
      b = build_beat({20'h00001, 5'd8, OPC_AUIPC}, 32'h0, 32'h0, FWD_REG, FWD_REG);
      b.inst_pc = 32'hFFFF_FFFF;
      issue_instruction(b);
      issue_instruction(build_beat({12'h800, 5'd1, 3'd7, 5'd9, OPC_LOAD},
                                   32'h0000_0100, 32'h0, FWD_REG, FWD_REG));
      issue_instruction(build_beat({7'h40, 5'd2, 5'd1, 3'd2, 5'd0, OPC_STORE},
                                   32'h0, 32'hDEAD_BEEF, FWD_REG, FWD_REG));
      issue_instruction(build_beat({7'h7F, 5'd2, 5'd1, 3'd1, 5'd31, OPC_BRANCH},
                                   32'h5, 32'h5, FWD_REG, FWD_REG));
      // Forwarding: the spare select, forwarding over x0, and a plain x0 read.
      issue_instruction(build_beat({7'h00, 5'd2, 5'd1, F3_XOR, 5'd3, OPC_OP},
                                   32'hAAAA_AAAA, 32'h5555_5555, FWD_SPARE, FWD_SPARE));
      issue_instruction(build_beat({7'h00, 5'd0, 5'd0, F3_OR, 5'd3, OPC_OP},
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, FWD_WB, FWD_MEM));
      issue_instruction(build_beat({7'h00, 5'd0, 5'd0, F3_OR, 5'd3, OPC_OP},
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, FWD_REG, FWD_REG));
      // Opcodes without an immediate, the all-zero and all-one words, and a flushed beat.
      issue_instruction(build_beat({20'hFFFFF, 5'd1, OPC_JAL},
                                   32'h1, 32'h2, FWD_REG, FWD_REG));
      issue_instruction(build_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, FWD_REG, FWD_REG));
      issue_instruction(build_beat(32'h0000_0000, 32'h7, 32'h9, FWD_WB, FWD_MEM));
      b = build_beat({7'h20, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_OP},
                     32'hFFFF_FFFF, 32'h1, FWD_WB, FWD_MEM);
      b.flush = 1'b1;
      issue_instruction(b);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         throttle = !(i >= 400 && i < 700);
         if (i == 1000)
            hold_off_armed = 1'b1;
         issue_instruction(random_beat());
      end
      req_bus.valid <= 1'b0;

      while (board.pending_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0 && board.pending_results.size() == 0)
         $display("[rv32i_decode_execute_stage_top] OK");
      else
         $display("[rv32i_decode_execute_stage_top] ERROR");
      $finish;
   end

endmodule
